/* rtl/core/bounded_deque_engine_unit_macros.svh */
// assertion helpers for the deque engine
// expects clk and rst in the scope of use
`ifndef BOUNDED_DEQUE_ENGINE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_ENGINE_UNIT_MACROS_SVH

// consequence holds in the same cycle
`define BDE_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// consequence holds in the next cycle
`define BDE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/bde_pkg.sv */
`timescale 1ns / 1ps

package bde_pkg;

  localparam int CMD_BITS    = 3;
  localparam int VALUE_BITS  = 32;
  localparam int POS_BITS    = 9;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 9;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic apply;
    logic rd_src;
    logic wr_shift;
    logic ins_put;
    logic era_done;
    logic rd_front;
    logic take_front;
    logic rd_back;
    logic load_out;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_insert;
    logic is_erase;
    logic op_ok;
    logic empty;
    logic ins_more;
    logic era_more;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/core/bde_if.sv */
`timescale 1ns / 1ps

interface bde_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [bde_pkg::CMD_BITS-1:0]         command;
  logic signed [bde_pkg::VALUE_BITS-1:0] item_value;
  logic [bde_pkg::POS_BITS-1:0]         position;

  modport source (output valid, command, item_value, position, input ready);
  modport sink   (input valid, command, item_value, position, output ready);
endinterface

interface bde_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [bde_pkg::STATUS_BITS-1:0]       status;
  logic signed [bde_pkg::VALUE_BITS-1:0] front_value;
  logic signed [bde_pkg::VALUE_BITS-1:0] back_value;
  logic [bde_pkg::COUNT_BITS-1:0]        entry_count;
  logic                                  is_empty;

  modport source (output valid, status, front_value, back_value, entry_count, is_empty,
                  input ready);
  modport sink   (input valid, status, front_value, back_value, entry_count, is_empty,
                  output ready);
endinterface

/* rtl/core/bounded_deque_engine_unit.sv */
`timescale 1ns / 1ps
// channel  dir  payload                                                 words
// req      in   command, item_value, position                          one per command
// rsp      out  status, front_value, back_value, entry_count, is_empty one per command
//
// push and pop: the command passes decide, front read, back read and load states; the
//   back read is skipped when the deque is left empty; ready returns with the result
// an accepted insert or erase adds a read and a write state per entry moved plus a
//   final state, set by the single read and single write port; rejected ones add none
// synchronous active-high reset empties the deque, the slot memory is not cleared
// a new command is taken while the previous result word still waits on rsp,
//   a stall on rsp holds that next command in its last cycle

module bounded_deque_engine_unit #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  bde_in_if.sink    req,
  bde_out_if.source rsp
);

  `include "bounded_deque_engine_unit_macros.svh"

  // command and status between sequencer and datapath
  bde_pkg::ctl_t ctl;
  bde_pkg::sts_t sts;

  // terms watched by the checks below
  logic req_take;
  logic rsp_shows_empty;
  logic rsp_marker;
  logic rsp_empty_err;
  logic rsp_none_held;

  // sequencer: one command at a time, walks the shift loops
  bde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .ready    (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath: circular slot memory, head and count, result register
  bde_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (req.command),
    .in_item_value   (req.item_value),
    .in_position     (req.position),
    .out_ready       (rsp.ready),
    .out_valid       (rsp.valid),
    .out_status      (rsp.status),
    .out_front_value (rsp.front_value),
    .out_back_value  (rsp.back_value),
    .out_entry_count (rsp.entry_count),
    .out_is_empty    (rsp.is_empty)
  );

  assign req_take        = req.valid && req.ready;
  assign rsp_shows_empty = rsp.valid && rsp.is_empty;
  assign rsp_marker      = (rsp.front_value == 32'hFFFF_FFFF) &&
                           (rsp.back_value == 32'hFFFF_FFFF);
  assign rsp_empty_err   = rsp.valid && (rsp.status == bde_pkg::ST_EMPTY);
  assign rsp_none_held   = rsp.is_empty && (rsp.entry_count == '0);

  // only one command in flight
  `BDE_ASSERT_NEXT(a_one_in_flight, req_take, !req.ready, "second command taken while busy")
  // an empty deque reports the all-ones marker at both ends
  `BDE_ASSERT_NOW(a_empty_marker, rsp_shows_empty, rsp_marker, "empty deque without marker")
  // an empty error only comes from an empty deque
  `BDE_ASSERT_NOW(a_empty_error, rsp_empty_err, rsp_none_held, "empty error with entries held")

endmodule

/* rtl/core/bde_datapath.sv */
`timescale 1ns / 1ps

module bde_datapath #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bde_pkg::ctl_t                          ctl,
  output bde_pkg::sts_t                          sts,
  input  logic [bde_pkg::CMD_BITS-1:0]           in_command,
  input  logic signed [bde_pkg::VALUE_BITS-1:0]  in_item_value,
  input  logic [bde_pkg::POS_BITS-1:0]           in_position,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [bde_pkg::STATUS_BITS-1:0]        out_status,
  output logic signed [bde_pkg::VALUE_BITS-1:0]  out_front_value,
  output logic signed [bde_pkg::VALUE_BITS-1:0]  out_back_value,
  output logic [bde_pkg::COUNT_BITS-1:0]         out_entry_count,
  output logic                                   out_is_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > bde_pkg::POS_BITS) ? CW : bde_pkg::POS_BITS;
  localparam logic [CW:0]   CAP_EXT   = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic signed [bde_pkg::VALUE_BITS-1:0] NONE_VALUE = '1;

  // latched item
  logic [bde_pkg::CMD_BITS-1:0]  cmd;
  logic signed [WORD_BITS-1:0]   val;
  logic [PW-1:0]                 pos;

  logic [AW-1:0]                 head;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 cursor;
  bde_pkg::status_t              st;
  logic signed [WORD_BITS-1:0]   front_word;

  logic [WORD_BITS-1:0]          mem [CAPACITY];
  logic [WORD_BITS-1:0]          rdata;

  bde_pkg::status_t              st_now;
  logic                          full;
  logic                          empty;
  logic [PW-1:0]                 count_ext;
  logic [CW-1:0]                 pos_cw;
  logic [AW-1:0]                 head_dec;
  logic [AW-1:0]                 head_inc;
  logic                          is_insert;
  logic                          is_erase;
  logic                          rd_en;
  logic [CW-1:0]                 rd_log;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [CW-1:0]                 wr_log;
  logic [AW-1:0]                 wr_addr;
  logic [WORD_BITS-1:0]          wr_data;
  logic                          tail_put_go;
  logic                          head_put_go;

  // logical index to slot, sum stays below twice the capacity
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(ofs);
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (count == CAP_COUNT);
  assign empty     = (count == '0);
  assign count_ext = PW'(count);
  assign pos_cw    = pos[CW-1:0];
  assign head_dec  = (head == '0) ? LAST_SLOT : head - 1'b1;
  assign head_inc  = wrap(head, CW'(1));
  assign is_insert = (cmd == bde_pkg::CMD_INSERT);
  assign is_erase  = (cmd == bde_pkg::CMD_ERASE);

  always_comb begin
    case (cmd)
      bde_pkg::CMD_PUSH_BACK,
      bde_pkg::CMD_PUSH_FRONT: st_now = full ? bde_pkg::ST_FULL : bde_pkg::ST_OK;
      bde_pkg::CMD_POP_BACK,
      bde_pkg::CMD_POP_FRONT:  st_now = empty ? bde_pkg::ST_EMPTY : bde_pkg::ST_OK;
      bde_pkg::CMD_INSERT: begin
        if (full) begin
          st_now = bde_pkg::ST_FULL;
        end else if (pos > count_ext) begin
          st_now = bde_pkg::ST_RANGE;
        end else begin
          st_now = bde_pkg::ST_OK;
        end
      end
      bde_pkg::CMD_ERASE: begin
        if (empty) begin
          st_now = bde_pkg::ST_EMPTY;
        end else if (pos >= count_ext) begin
          st_now = bde_pkg::ST_RANGE;
        end else begin
          st_now = bde_pkg::ST_OK;
        end
      end
      default: st_now = bde_pkg::ST_OK;
    endcase
  end

  assign tail_put_go = ctl.apply && (st_now == bde_pkg::ST_OK) &&
                       (cmd == bde_pkg::CMD_PUSH_BACK);
  assign head_put_go = ctl.apply && (st_now == bde_pkg::ST_OK) &&
                       (cmd == bde_pkg::CMD_PUSH_FRONT);

  // read port address
  assign rd_en = ctl.rd_src || ctl.rd_front || ctl.rd_back;
  always_comb begin
    if (ctl.rd_back) begin
      rd_log = count - 1'b1;
    end else if (ctl.rd_src) begin
      rd_log = is_insert ? cursor - 1'b1 : cursor + 1'b1;
    end else begin
      rd_log = '0;
    end
  end
  assign rd_addr = wrap(head, rd_log);

  // write port address and data
  assign wr_en = tail_put_go || head_put_go || ctl.wr_shift || ctl.ins_put;
  always_comb begin
    if (ctl.wr_shift) begin
      wr_log = cursor;
    end else if (ctl.ins_put) begin
      wr_log = pos_cw;
    end else begin
      wr_log = count;
    end
  end
  assign wr_addr = head_put_go ? head_dec : wrap(head, wr_log);
  assign wr_data = ctl.wr_shift ? rdata : val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd <= in_command;
      val <= WORD_BITS'(in_item_value);
      pos <= PW'(in_position);
    end
    if (ctl.apply) begin
      st <= st_now;
    end
    if (ctl.take_front) begin
      front_word <= $signed(rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      cursor <= '0;
    end else begin
      if (ctl.apply && (st_now == bde_pkg::ST_OK)) begin
        case (cmd)
          bde_pkg::CMD_PUSH_BACK:  count <= count + 1'b1;
          bde_pkg::CMD_PUSH_FRONT: begin
            head  <= head_dec;
            count <= count + 1'b1;
          end
          bde_pkg::CMD_POP_BACK:   count <= count - 1'b1;
          bde_pkg::CMD_POP_FRONT:  begin
            head  <= head_inc;
            count <= count - 1'b1;
          end
          bde_pkg::CMD_INSERT:     cursor <= count;
          bde_pkg::CMD_ERASE:      cursor <= pos_cw;
          default:                 ;
        endcase
      end
      if (ctl.wr_shift) begin
        cursor <= is_insert ? cursor - 1'b1 : cursor + 1'b1;
      end
      if (ctl.ins_put) begin
        count <= count + 1'b1;
      end
      if (ctl.era_done) begin
        count <= count - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status      <= st;
      out_front_value <= empty ? NONE_VALUE : bde_pkg::VALUE_BITS'(front_word);
      out_back_value  <= empty ? NONE_VALUE : bde_pkg::VALUE_BITS'($signed(rdata));
      out_entry_count <= bde_pkg::COUNT_BITS'(count);
      out_is_empty    <= empty;
    end
  end

  assign sts.is_insert = is_insert;
  assign sts.is_erase  = is_erase;
  assign sts.op_ok     = (st_now == bde_pkg::ST_OK);
  assign sts.empty     = empty;
  assign sts.ins_more  = (cursor > pos_cw);
  assign sts.era_more  = ((CW + 1)'(cursor) + 1'b1) < (CW + 1)'(count);
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

/* rtl/core/bde_ctrl.sv */
`timescale 1ns / 1ps

module bde_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          ready,
  input  bde_pkg::sts_t sts,
  output bde_pkg::ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_LOOP,
    S_INS_WR,
    S_ERA_LOOP,
    S_ERA_WR,
    S_RD_F,
    S_RD_B,
    S_LOAD
  } state_t;

  state_t state;

  always_comb begin
    ctl = '0;
    case (state)
      S_IDLE:     ctl.latch_in = in_valid && ready;
      S_DECIDE:   ctl.apply = 1'b1;
      S_INS_LOOP: begin
        ctl.rd_src  = sts.ins_more;
        ctl.ins_put = !sts.ins_more;
      end
      S_INS_WR:   ctl.wr_shift = 1'b1;
      S_ERA_LOOP: begin
        ctl.rd_src   = sts.era_more;
        ctl.era_done = !sts.era_more;
      end
      S_ERA_WR:   ctl.wr_shift = 1'b1;
      S_RD_F:     ctl.rd_front = !sts.empty;
      S_RD_B: begin
        ctl.take_front = 1'b1;
        ctl.rd_back    = 1'b1;
      end
      S_LOAD:     ctl.load_out = !sts.out_busy;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && ready) begin
            state <= S_DECIDE;
            ready <= 1'b0;
          end
        end
        S_DECIDE: begin
          if (sts.is_insert && sts.op_ok) begin
            state <= S_INS_LOOP;
          end else if (sts.is_erase && sts.op_ok) begin
            state <= S_ERA_LOOP;
          end else begin
            state <= S_RD_F;
          end
        end
        S_INS_LOOP: state <= sts.ins_more ? S_INS_WR : S_RD_F;
        S_INS_WR:   state <= S_INS_LOOP;
        S_ERA_LOOP: state <= sts.era_more ? S_ERA_WR : S_RD_F;
        S_ERA_WR:   state <= S_ERA_LOOP;
        S_RD_F:     state <= sts.empty ? S_LOAD : S_RD_B;
        S_RD_B:     state <= S_LOAD;
        S_LOAD: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

endmodule
